@@ rtl/crt_pkg.sv @@
package crt_pkg;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV_AN,
		CMD_DIV_BM,
		CMD_DIV_AM,
		CMD_DIFF,
		CMD_GCD_INIT,
		CMD_DIV_XY,
		CMD_DIV_DG,
		CMD_DIV_NG,
		CMD_DIV_MG,
		CMD_INV_INIT,
		CMD_DIV_NM2,
		CMD_DIV_R,
		CMD_MUL_QU,
		CMD_INV_UPD,
		CMD_INV_FIX,
		CMD_MUL_DI,
		CMD_DIV_T,
		CMD_MUL_NT,
		CMD_FINAL,
		CMD_FAIL
	} cmd_t;

	// Status returned by the datapath
	typedef struct packed {
		logic div_done;
		logic zero_mod;
		logic y_zero;
		logic r1_zero;
		logic divisible;
	} stat_t;

endpackage

@@ rtl/crt_div.sv @@
module crt_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           long_mode,
	input  logic [2*W-1:0] dividend,
	input  logic [W-1:0]   divisor,
	output logic           done,
	output logic [2*W-1:0] quot,
	output logic [W-1:0]   rem
);
	localparam int CW = $clog2(2*W+1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [2*W-1:0] quot_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_nx;
	logic          ge;

	// one restoring step per cycle
	always_comb begin
		rem_sh = {rem_q, quot_q[2*W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= long_mode ? CW'(2*W) : CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= long_mode ? dividend : {dividend[W-1:0], {W{1'b0}}};
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[2*W-2:0], ge};
			rem_q  <= rem_nx[W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

@@ rtl/crt_dp.sv @@
module crt_dp #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  crt_pkg::cmd_t  cmd,
	input  logic [W-1:0]   in_a,
	input  logic [W-1:0]   in_n,
	input  logic [W-1:0]   in_b,
	input  logic [W-1:0]   in_m,
	output crt_pkg::stat_t stat,
	output logic [2*W-1:0] sol,
	output logic           found
);
	import crt_pkg::*;

	logic [W-1:0]   a_q, n_q, b_q, m_q, am_q, d_q, x_q, y_q;
	logic [W-1:0]   dg_q, n2_q, m2_q, r0_q, r1_q, q_q, rr_q;
	logic [W-1:0]   u0_q, u1_q, inv_q, t_q;
	logic           dok_q, s0n_q, s1n_q, found_q;
	logic [2*W-1:0] prod_q, sol_q;
	cmd_t           op_q;

	logic           dv_start, dv_long, dv_done;
	logic [2*W-1:0] dv_dvd, dv_quot;
	logic [W-1:0]   dv_dvs, dv_rem;
	logic [W-1:0]   inv_tmp;
	logic [W:0]     diff_wrap;

	// divider operand select
	always_comb begin
		dv_start = 1'b1;
		dv_long  = 1'b0;
		dv_dvd   = '0;
		dv_dvs   = '0;
		case (cmd)
			CMD_DIV_AN:  begin dv_dvd = {{W{1'b0}}, a_q};  dv_dvs = n_q;  end
			CMD_DIV_BM:  begin dv_dvd = {{W{1'b0}}, b_q};  dv_dvs = m_q;  end
			CMD_DIV_AM:  begin dv_dvd = {{W{1'b0}}, a_q};  dv_dvs = m_q;  end
			CMD_DIV_XY:  begin dv_dvd = {{W{1'b0}}, x_q};  dv_dvs = y_q;  end
			CMD_DIV_DG:  begin dv_dvd = {{W{1'b0}}, d_q};  dv_dvs = x_q;  end
			CMD_DIV_NG:  begin dv_dvd = {{W{1'b0}}, n_q};  dv_dvs = x_q;  end
			CMD_DIV_MG:  begin dv_dvd = {{W{1'b0}}, m_q};  dv_dvs = x_q;  end
			CMD_DIV_NM2: begin dv_dvd = {{W{1'b0}}, n2_q}; dv_dvs = m2_q; end
			CMD_DIV_R:   begin dv_dvd = {{W{1'b0}}, r0_q}; dv_dvs = r1_q; end
			CMD_DIV_T: begin
				dv_dvd  = prod_q;
				dv_dvs  = m2_q;
				dv_long = 1'b1;
			end
			default: dv_start = 1'b0;
		endcase
	end

	crt_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (dv_start),
		.long_mode (dv_long),
		.dividend  (dv_dvd),
		.divisor   (dv_dvs),
		.done      (dv_done),
		.quot      (dv_quot),
		.rem       (dv_rem)
	);

	// wrap-around difference and inverse sign fixup
	always_comb begin
		diff_wrap = {1'b0, b_q} + {1'b0, m_q} - {1'b0, am_q};
		inv_tmp   = (s0n_q && (u0_q != '0)) ? (m2_q - u0_q) : u0_q;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (dv_start)
			op_q <= cmd;
		if (dv_done) begin
			case (op_q)
				CMD_DIV_AN:  a_q  <= dv_rem;
				CMD_DIV_BM:  b_q  <= dv_rem;
				CMD_DIV_AM:  am_q <= dv_rem;
				CMD_DIV_XY: begin
					x_q <= y_q;
					y_q <= dv_rem;
				end
				CMD_DIV_DG: begin
					dg_q  <= dv_quot[W-1:0];
					dok_q <= (dv_rem == '0);
				end
				CMD_DIV_NG:  n2_q <= dv_quot[W-1:0];
				CMD_DIV_MG:  m2_q <= dv_quot[W-1:0];
				CMD_DIV_NM2: r1_q <= dv_rem;
				CMD_DIV_R: begin
					q_q  <= dv_quot[W-1:0];
					rr_q <= dv_rem;
				end
				CMD_DIV_T:   t_q  <= dv_rem;
				default: ;
			endcase
		end
		case (cmd)
			CMD_LOAD: begin
				a_q <= in_a;
				n_q <= in_n;
				b_q <= in_b;
				m_q <= in_m;
			end
			CMD_DIFF: d_q <= (b_q >= am_q) ? (b_q - am_q) : diff_wrap[W-1:0];
			CMD_GCD_INIT: begin
				x_q <= n_q;
				y_q <= m_q;
			end
			CMD_INV_INIT: begin
				r0_q  <= m2_q;
				u0_q  <= '0;
				u1_q  <= W'(1);
				s0n_q <= 1'b0;
				s1n_q <= 1'b0;
			end
			CMD_MUL_QU: prod_q <= q_q * u1_q;
			CMD_INV_UPD: begin
				r0_q  <= r1_q;
				r1_q  <= rr_q;
				u0_q  <= u1_q;
				u1_q  <= u0_q + prod_q[W-1:0];
				s0n_q <= s1n_q;
				s1n_q <= ~s1n_q;
			end
			CMD_INV_FIX: inv_q  <= (inv_tmp == m2_q) ? '0 : inv_tmp;
			CMD_MUL_DI:  prod_q <= dg_q * inv_q;
			CMD_MUL_NT:  prod_q <= n_q * t_q;
			CMD_FINAL: begin
				sol_q   <= {{W{1'b0}}, a_q} + prod_q;
				found_q <= 1'b1;
			end
			CMD_FAIL: begin
				sol_q   <= '0;
				found_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// status to controller
	always_comb begin
		stat.div_done  = dv_done;
		stat.zero_mod  = (n_q == '0) || (m_q == '0);
		stat.y_zero    = (y_q == '0);
		stat.r1_zero   = (r1_q == '0);
		stat.divisible = dok_q;
	end

	assign sol   = sol_q;
	assign found = found_q;
endmodule

@@ rtl/crt_ctrl.sv @@
module crt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  crt_pkg::stat_t stat,
	output crt_pkg::cmd_t  cmd
);
	import crt_pkg::*;

	typedef enum logic [25:0] {
		S_IDLE   = 26'b1 << 0,
		S_CHECK  = 26'b1 << 1,
		S_AN     = 26'b1 << 2,
		S_BM     = 26'b1 << 3,
		S_AM     = 26'b1 << 4,
		S_DIFF   = 26'b1 << 5,
		S_GINIT  = 26'b1 << 6,
		S_GTEST  = 26'b1 << 7,
		S_GDIV   = 26'b1 << 8,
		S_DG     = 26'b1 << 9,
		S_DGTEST = 26'b1 << 10,
		S_NG     = 26'b1 << 11,
		S_MG     = 26'b1 << 12,
		S_IINIT  = 26'b1 << 13,
		S_NM2    = 26'b1 << 14,
		S_ITEST  = 26'b1 << 15,
		S_IDIV   = 26'b1 << 16,
		S_IMUL   = 26'b1 << 17,
		S_IUPD   = 26'b1 << 18,
		S_IFIX   = 26'b1 << 19,
		S_MDI    = 26'b1 << 20,
		S_T      = 26'b1 << 21,
		S_MNT    = 26'b1 << 22,
		S_FIN    = 26'b1 << 23,
		S_FAIL   = 26'b1 << 24,
		S_WAIT   = 26'b1 << 25
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;
	logic   ovalid_q, out_set, out_free;

	assign out_free = !ovalid_q || m_tready;

	// sequencer
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = CMD_NONE;
		out_set = 1'b0;
		unique case (state_q)
			S_IDLE: if (s_tvalid) begin
				cmd     = CMD_LOAD;
				state_d = S_CHECK;
			end
			S_CHECK:  state_d = stat.zero_mod ? S_FAIL : S_AN;
			S_AN: begin cmd = CMD_DIV_AN; ret_d = S_BM;   state_d = S_WAIT; end
			S_BM: begin cmd = CMD_DIV_BM; ret_d = S_AM;   state_d = S_WAIT; end
			S_AM: begin cmd = CMD_DIV_AM; ret_d = S_DIFF; state_d = S_WAIT; end
			S_DIFF:  begin cmd = CMD_DIFF;     state_d = S_GINIT; end
			S_GINIT: begin cmd = CMD_GCD_INIT; state_d = S_GTEST; end
			S_GTEST: state_d = stat.y_zero ? S_DG : S_GDIV;
			S_GDIV: begin cmd = CMD_DIV_XY; ret_d = S_GTEST; state_d = S_WAIT; end
			S_DG:   begin cmd = CMD_DIV_DG; ret_d = S_DGTEST; state_d = S_WAIT; end
			S_DGTEST: state_d = stat.divisible ? S_NG : S_FAIL;
			S_NG:   begin cmd = CMD_DIV_NG; ret_d = S_MG;    state_d = S_WAIT; end
			S_MG:   begin cmd = CMD_DIV_MG; ret_d = S_IINIT; state_d = S_WAIT; end
			S_IINIT: begin cmd = CMD_INV_INIT; state_d = S_NM2; end
			S_NM2:  begin cmd = CMD_DIV_NM2; ret_d = S_ITEST; state_d = S_WAIT; end
			S_ITEST: state_d = stat.r1_zero ? S_IFIX : S_IDIV;
			S_IDIV: begin cmd = CMD_DIV_R; ret_d = S_IMUL; state_d = S_WAIT; end
			S_IMUL: begin cmd = CMD_MUL_QU;  state_d = S_IUPD; end
			S_IUPD: begin cmd = CMD_INV_UPD; state_d = S_ITEST; end
			S_IFIX: begin cmd = CMD_INV_FIX; state_d = S_MDI; end
			S_MDI:  begin cmd = CMD_MUL_DI;  state_d = S_T; end
			S_T:    begin cmd = CMD_DIV_T; ret_d = S_MNT; state_d = S_WAIT; end
			S_MNT:  begin cmd = CMD_MUL_NT;  state_d = S_FIN; end
			S_FIN: if (out_free) begin
				cmd     = CMD_FINAL;
				out_set = 1'b1;
				state_d = S_IDLE;
			end
			S_FAIL: if (out_free) begin
				cmd     = CMD_FAIL;
				out_set = 1'b1;
				state_d = S_IDLE;
			end
			S_WAIT: if (stat.div_done)
				state_d = ret_q;
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (out_set)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
endmodule

@@ rtl/two_modulus_crt_solver.sv @@
// Solves x = a (mod n), x = b (mod m) for moduli that need not be coprime and
// returns the least non-negative x below lcm(n, m), with found = 1, or zero with
// found = 0 when gcd(n, m) does not divide b - a or a modulus is zero. Only the
// low MOD_WIDTH bits of each input field are used. One item is in work at a
// time; s_tready is high only while the sequencer is idle, and a finished
// result may wait on the output while the next beat is accepted. Every
// division runs on one shared restoring divider at one quotient bit per cycle:
// MOD_WIDTH quotient bits each, 2*MOD_WIDTH for the final reduction. The time
// an item takes from the accepting cycle grows with the steps of the gcd loop
// and of the inverse loop, plus any time the previous result still waits on
// the output; it is longest for the longest Euclid chains. A zero modulus
// skips all divisions and goes straight to the failed result. Results leave
// in input order, one per input beat.
module two_modulus_crt_solver #(
	parameter int MOD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// residue_a [31:0], modulus_n [63:32], residue_b [95:64], modulus_m [127:96]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// solution [63:0]
	output logic [63:0]  m_tdata,
	// found [0]
	output logic [0:0]   m_tuser
);
	import crt_pkg::*;

	localparam int W = MOD_WIDTH;

	cmd_t           cmd;
	stat_t          stat;
	logic [2*W-1:0] sol;
	logic           found;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crt_dp #(.W(W)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.in_a   (s_tdata[W-1:0]),
		.in_n   (s_tdata[32+W-1:32]),
		.in_b   (s_tdata[64+W-1:64]),
		.in_m   (s_tdata[96+W-1:96]),
		.stat   (stat),
		.sol    (sol),
		.found  (found)
	);

	assign m_tdata    = 64'(sol);
	assign m_tuser[0] = found;

	// no solution is reported as zero
	a_nosol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
		else $error("no-solution result is not zero");

	// one item at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// solution fits in twice the modulus width
	a_sol_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> (2 * MOD_WIDTH)) == 64'd0)
		else $error("solution wider than lcm range");
endmodule
